// ===== rtl/otr_pkg.sv =====
package otr_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int ENTRY_BITS = 64;
    localparam int PTR_W      = 32;
    localparam int DATA_W     = 64;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // lookup for one read request, taken from the pointer state
    typedef struct packed {
        logic              found;
        logic [PTR_W-1:0]  index;
        logic [PTR_W-1:0]  lost;
        logic [SLOT_W-1:0] slot;
    } t_rd_info;

endpackage

// ===== rtl/overwriting_trace_ring.sv =====
// channel | dir | tdata (low bit up)                          | tuser
// s_axis  | in  | entry_in[63:0]                              | cmd
// m_axis  | out | entry_index[31:0] entry_out[95:32] lost[127:96] | found
// one request per cycle while s_axis_tready is high; a record gives no result, a read gives one
// result, registered first in the slot read register and then in the output register
// the slot memory port and the pointer compare/add set the single-cycle rate
// synchronous reset clears pointers, lost count and valids; slots stay unwritten
// s_axis_tready drops only while both result stages are full and m_axis_tready is low
module overwriting_trace_ring import otr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,   // entry_in
    input  logic [0:0]          s_axis_tuser,   // cmd
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [127:0]        m_axis_tdata,   // entry_index, entry_out, lost_count
    output logic [0:0]          m_axis_tuser    // found
);

    t_rd_info                info;
    logic [SLOT_W-1:0]       wslot;
    logic                    acc;
    logic                    rec;
    logic                    rd;
    logic                    s1_adv;

    logic [ENTRY_BITS-1:0]   r_mem [SLOTS];
    logic [ENTRY_BITS-1:0]   r_rdata;

    logic                    r_s1_valid;
    logic                    r_s1_found;
    logic [PTR_W-1:0]        r_s1_index;
    logic [PTR_W-1:0]        r_s1_lost;

    logic                    r_m_valid;
    logic                    r_m_found;
    logic [PTR_W-1:0]        r_m_index;
    logic [DATA_W-1:0]       r_m_entry;
    logic [PTR_W-1:0]        r_m_lost;

    assign s1_adv        = !r_m_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign rec           = acc && (s_axis_tuser[0] == CMD_RECORD);
    assign rd            = acc && (s_axis_tuser[0] == CMD_READ);

    otr_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec),
        .i_rd    (rd),
        .o_info  (info),
        .o_wslot (wslot)
    );

    // slot memory
    always_ff @(posedge i_clk) begin
        if (rec) begin
            r_mem[wslot] <= s_axis_tdata[ENTRY_BITS-1:0];
        end
        if (rd) begin
            r_rdata <= r_mem[info.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rd) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (rd) begin
            r_s1_found <= info.found;
            r_s1_index <= info.index;
            r_s1_lost  <= info.lost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_adv) begin
            r_m_valid <= r_s1_valid;
        end
        if (s1_adv && r_s1_valid) begin
            r_m_found <= r_s1_found;
            r_m_index <= r_s1_index;
            r_m_entry <= r_s1_found ? DATA_W'(r_rdata) : '0;
            r_m_lost  <= r_s1_lost;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = {r_m_lost, r_m_entry, r_m_index};
    assign m_axis_tuser[0] = r_m_found;

`ifndef SYNTHESIS
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_m_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while both result stages are stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_found) |-> ((r_m_index == '0) && (r_m_entry == '0)))
        else $error("empty read carries nonzero index or entry");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> r_m_valid)
        else $error("read result dropped between stages");
`endif

endmodule

// ===== rtl/otr_ctl.sv =====
module otr_ctl import otr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rec,
    input  logic              i_rd,
    output t_rd_info          o_info,
    output logic [SLOT_W-1:0] o_wslot
);

    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W-1:0] r_lost;
    logic [PTR_W-1:0] n_lost;
    logic [PTR_W-1:0] n_rd;
    logic [PTR_W-1:0] span;
    logic [PTR_W-1:0] excess;
    logic [PTR_W:0]   sum;
    logic             lapped;
    logic             empty;

    always_comb begin
        span   = r_wp - r_rp;
        empty  = (span == '0);
        lapped = (span > PTR_W'(SLOTS));
        excess = span - PTR_W'(SLOTS);
        sum    = {1'b0, r_lost} + {1'b0, excess};
        if (lapped) begin
            n_lost = sum[PTR_W] ? '1 : sum[PTR_W-1:0];
            n_rd   = r_wp - PTR_W'(SLOTS);
        end else begin
            n_lost = r_lost;
            n_rd   = r_rp;
        end
        o_info.found = !empty;
        o_info.index = empty ? '0 : n_rd;
        o_info.lost  = empty ? r_lost : n_lost;
        o_info.slot  = SLOT_W'(n_rd % PTR_W'(SLOTS));
        o_wslot      = SLOT_W'(r_wp % PTR_W'(SLOTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_lost <= '0;
        end else begin
            if (i_rec) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd && !empty) begin
                r_rp   <= n_rd + 1'b1;
                r_lost <= n_lost;
            end
        end
    end

`ifndef SYNTHESIS
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rec |=> (r_wp == $past(r_wp) + 1'b1))
        else $error("write pointer did not advance on record");

    a_lost_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_lost >= $past(r_lost)))
        else $error("lost counter went down");

    a_rd_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd && !empty && !i_rec) |=> ((r_wp - r_rp) < PTR_W'(SLOTS)))
        else $error("reader left outside the surviving window");
`endif

endmodule
